### rtl/core/conv2d_3x3_nhwc_stride_pad_core_macros.svh
// Assertion macros used by the conv2d core datapath.
`ifndef CONV2D_3X3_NHWC_STRIDE_PAD_CORE_MACROS_SVH
`define CONV2D_3X3_NHWC_STRIDE_PAD_CORE_MACROS_SVH

// Property sampled on clk, off while rst_n is low.
`define C2D_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a check in the next cycle.
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/c2d_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package c2d_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 64;
  localparam int MAX_FILTERS  = 64;
  localparam int KERNEL_SIZE  = 3;
  localparam int STEP_MAX     = 4;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int FLT_W  = $clog2(MAX_FILTERS);
  localparam int SLOT_W = $clog2(KERNEL_SIZE);
  localparam int KSEL_W = $clog2(KERNEL_SIZE);
  localparam int TAP_W  = $clog2(KERNEL_SIZE * KERNEL_SIZE);

  // configuration field widths
  localparam int DIM_W  = 9;
  localparam int CNT_W  = 7;
  localparam int STEP_W = 3;
  localparam int CFG_DW = 9;
  localparam int CFG_IW = 3;

  // window index and window end coordinate widths
  localparam int IDX_W = ROW_W + 1;
  localparam int END_W = ROW_W + 2;

  localparam int DATA_W = 16;
  localparam int BIAS_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = 48;

  localparam int LINE_DEPTH = KERNEL_SIZE * MAX_WIDTH * MAX_CHANNELS;
  localparam int WGT_DEPTH  = KERNEL_SIZE * KERNEL_SIZE * MAX_CHANNELS * MAX_FILTERS;

  localparam int RST_HEIGHT   = 224;
  localparam int RST_WIDTH    = 224;
  localparam int RST_CHANNELS = 64;
  localparam int RST_FILTERS  = 64;
  localparam int RST_STEP     = 2;
  localparam int RST_PAD      = 1;

  typedef enum logic [CFG_IW-1:0] {
    REG_HEIGHT   = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_FILTERS  = 3'd3,
    REG_STEP     = 3'd4,
    REG_PAD      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_ACT    = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_SCAN,
    ST_COL_SCAN,
    ST_WIN_INIT,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cfg_we;
    logic row_adv;
    logic col_adv;
    logic win_init;
    logic bias_load;
    logic mac_step;
    logic filt_next;
    logic win_next;
    logic emit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic px_last;
    logic row_match;
    logic col_match;
    logic no_window;
    logic mac_end;
    logic pipe_busy;
    logic out_free;
    logic filt_last;
    logic win_last;
  } stat_t;

endpackage

### rtl/core/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/c2d_ctrl.sv
// Sequencing state machine: window scan, filter loop, MAC loop, result hand-off.
module c2d_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_operation,
  input  logic                 cfg_valid,
  input  c2d_pkg::stat_t       st,
  output logic                 in_stall,
  output logic                 cfg_ready,
  output c2d_pkg::cmd_t        cmd
);

  c2d_pkg::state_t state_r, state_nxt;
  c2d_pkg::op_t    op;

  assign op = c2d_pkg::op_t'(in_operation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c2d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      c2d_pkg::ST_IDLE: begin
        if (in_valid && op == c2d_pkg::OP_ACT && st.px_last) begin
          state_nxt = c2d_pkg::ST_ROW_SCAN;
        end
      end
      c2d_pkg::ST_ROW_SCAN: begin
        if (!st.row_match) begin
          state_nxt = c2d_pkg::ST_COL_SCAN;
        end
      end
      c2d_pkg::ST_COL_SCAN: begin
        if (!st.col_match) begin
          state_nxt = c2d_pkg::ST_WIN_INIT;
        end
      end
      c2d_pkg::ST_WIN_INIT: begin
        state_nxt = st.no_window ? c2d_pkg::ST_COMMIT : c2d_pkg::ST_BIAS;
      end
      c2d_pkg::ST_BIAS: state_nxt = c2d_pkg::ST_MAC;
      c2d_pkg::ST_MAC: begin
        if (st.mac_end) begin
          state_nxt = c2d_pkg::ST_DRAIN;
        end
      end
      c2d_pkg::ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_nxt = c2d_pkg::ST_EMIT;
        end
      end
      c2d_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_nxt = (st.filt_last && st.win_last) ? c2d_pkg::ST_COMMIT : c2d_pkg::ST_BIAS;
        end
      end
      c2d_pkg::ST_COMMIT: state_nxt = c2d_pkg::ST_IDLE;
      default: state_nxt = c2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      c2d_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.accept = in_valid;
        cmd.cfg_we = cfg_valid;
      end
      c2d_pkg::ST_ROW_SCAN: cmd.row_adv   = st.row_match;
      c2d_pkg::ST_COL_SCAN: cmd.col_adv   = st.col_match;
      c2d_pkg::ST_WIN_INIT: cmd.win_init  = 1'b1;
      c2d_pkg::ST_BIAS:     cmd.bias_load = 1'b1;
      c2d_pkg::ST_MAC:      cmd.mac_step  = 1'b1;
      c2d_pkg::ST_DRAIN:    cmd           = '0;
      c2d_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (!st.filt_last) begin
            cmd.filt_next = 1'b1;
          end else if (!st.win_last) begin
            cmd.win_next = 1'b1;
          end
        end
      end
      c2d_pkg::ST_COMMIT: cmd.commit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/c2d_dp.sv
// Datapath: config, pixel position, window cursors, stores, MAC and result register.
`include "conv2d_3x3_nhwc_stride_pad_core_macros.svh"

module c2d_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  c2d_pkg::cmd_t                     cmd,
  output c2d_pkg::stat_t                    st,
  input  logic [1:0]                        in_operation,
  input  logic signed [c2d_pkg::DATA_W-1:0] in_data,
  input  logic signed [c2d_pkg::BIAS_W-1:0] in_bias_value,
  input  logic [1:0]                        in_kernel_row,
  input  logic [1:0]                        in_kernel_col,
  input  logic [c2d_pkg::CH_W-1:0]          in_in_channel,
  input  logic [c2d_pkg::FLT_W-1:0]         in_filter_index,
  input  logic [c2d_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [c2d_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [7:0]                        out_row,
  output logic [7:0]                        out_col,
  output logic [c2d_pkg::FLT_W-1:0]         out_filter,
  output logic signed [c2d_pkg::SUM_W-1:0]  out_sum,
  output logic                              out_last_of_run
);

  localparam int DW = c2d_pkg::DIM_W;
  localparam int EW = c2d_pkg::END_W;
  localparam int IW = c2d_pkg::IDX_W;

  // configuration
  logic [DW-1:0]              h_r, w_r;
  logic [c2d_pkg::CNT_W-1:0]  c_r, f_r;
  logic [c2d_pkg::STEP_W-1:0] s_r;
  logic                       p_r;

  logic [DW-1:0]              h_eff, w_eff;
  logic [c2d_pkg::CNT_W-1:0]  c_eff, f_eff;
  logic [c2d_pkg::STEP_W-1:0] s_eff;
  logic [c2d_pkg::CH_W-1:0]   cm1;
  logic [c2d_pkg::FLT_W-1:0]  fm1;
  logic [EW-1:0]              hm1, wm1, e0, s_ext;
  logic                       new_p, cfg_hit;

  // pixel position
  logic [c2d_pkg::ROW_W-1:0]  pr_r;
  logic [c2d_pkg::COL_W-1:0]  pc_r;
  logic [c2d_pkg::CH_W-1:0]   pch_r;
  logic [c2d_pkg::SLOT_W-1:0] pslot_r;

  // window bases and scan cursors (index, window end coordinate)
  logic [IW-1:0] ri_r, cj_r, si_r, sj_r, wi_r, wj_r;
  logic [EW-1:0] re_r, ce_r, sie_r, sje_r, wie_r, wje_r;

  // loop counters
  logic [c2d_pkg::FLT_W-1:0]  fi_r;
  logic [c2d_pkg::KSEL_W-1:0] tl_r, tm_r;
  logic [c2d_pkg::CH_W-1:0]   cc_r;

  // MAC pipe
  logic                              b1_r, d1_r, v2_r;
  logic signed [c2d_pkg::PROD_W-1:0] prod_r;
  logic signed [c2d_pkg::SUM_W-1:0]  acc_r;
  logic [c2d_pkg::DATA_W-1:0]        line_q, wgt_q;
  logic [c2d_pkg::BIAS_W-1:0]        bias_q;

  // result register
  logic                             out_valid_r, out_last_r;
  logic [7:0]                       out_row_r, out_col_r;
  logic [c2d_pkg::FLT_W-1:0]        out_filter_r;
  logic signed [c2d_pkg::SUM_W-1:0] out_sum_r;

  c2d_pkg::op_t op;
  logic         row_ok_e, col_ok_e, end_col, end_row, pipe_busy, out_free;
  logic [EW-1:0] lastr, lastc, rr1, cc1, dd;
  logic [2:0]    slot_tmp;
  logic [c2d_pkg::SLOT_W-1:0] slot_sel;
  logic [c2d_pkg::COL_W-1:0]  col_sel;
  logic          tap_ok, tap_last, ch_last, mac_issue;
  logic [c2d_pkg::TAP_W-1:0]  rd_tap, wr_tap;
  logic          wgt_we, line_we, bias_we;

  assign op = c2d_pkg::op_t'(in_operation);

  // effective (clamped) configuration
  always_comb begin
    h_eff = (h_r == '0) ? DW'(1) :
            (h_r > DW'(c2d_pkg::MAX_HEIGHT)) ? DW'(c2d_pkg::MAX_HEIGHT) : h_r;
    w_eff = (w_r == '0) ? DW'(1) :
            (w_r > DW'(c2d_pkg::MAX_WIDTH)) ? DW'(c2d_pkg::MAX_WIDTH) : w_r;
    c_eff = (c_r == '0) ? c2d_pkg::CNT_W'(1) :
            (c_r > c2d_pkg::CNT_W'(c2d_pkg::MAX_CHANNELS)) ?
            c2d_pkg::CNT_W'(c2d_pkg::MAX_CHANNELS) : c_r;
    f_eff = (f_r == '0) ? c2d_pkg::CNT_W'(1) :
            (f_r > c2d_pkg::CNT_W'(c2d_pkg::MAX_FILTERS)) ?
            c2d_pkg::CNT_W'(c2d_pkg::MAX_FILTERS) : f_r;
    s_eff = (s_r == '0) ? c2d_pkg::STEP_W'(1) :
            (s_r > c2d_pkg::STEP_W'(c2d_pkg::STEP_MAX)) ?
            c2d_pkg::STEP_W'(c2d_pkg::STEP_MAX) : s_r;
    cm1   = c2d_pkg::CH_W'(c_eff - c2d_pkg::CNT_W'(1));
    fm1   = c2d_pkg::FLT_W'(f_eff - c2d_pkg::CNT_W'(1));
    hm1   = EW'(h_eff) - EW'(1);
    wm1   = EW'(w_eff) - EW'(1);
    s_ext = EW'(s_eff);
    e0    = EW'(2) - EW'(p_r);
  end

  assign cfg_hit = (cfg_index <= c2d_pkg::CFG_IW'(c2d_pkg::REG_PAD));
  assign new_p   = (cfg_index == c2d_pkg::REG_PAD) ? cfg_data[0] : p_r;

  // window end e = i*s - p + 2; its last real row is min(e, H-1); window exists if e <= H-1+p
  assign row_ok_e = (sie_r <= hm1 + EW'(p_r));
  assign lastr    = (sie_r >= hm1) ? hm1 : sie_r;
  assign col_ok_e = (sje_r <= wm1 + EW'(p_r));
  assign lastc    = (sje_r >= wm1) ? wm1 : sje_r;

  // tap geometry: rr1/cc1 are image row/column plus one
  always_comb begin
    rr1      = wie_r + EW'(tl_r) - EW'(1);
    cc1      = wje_r + EW'(tm_r) - EW'(1);
    tap_ok   = (rr1 != '0) && (rr1 <= EW'(h_eff)) && (cc1 != '0) && (cc1 <= EW'(w_eff));
    dd       = EW'(pr_r) + EW'(1) - rr1;
    slot_tmp = 3'(pslot_r) + 3'd3 - 3'(dd[1:0]);
    slot_sel = (slot_tmp >= 3'd3) ? c2d_pkg::SLOT_W'(slot_tmp - 3'd3)
                                  : c2d_pkg::SLOT_W'(slot_tmp);
    col_sel  = c2d_pkg::COL_W'(cc1 - EW'(1));
    rd_tap   = c2d_pkg::TAP_W'({tl_r, 1'b0}) + c2d_pkg::TAP_W'(tl_r) + c2d_pkg::TAP_W'(tm_r);
    wr_tap   = c2d_pkg::TAP_W'({in_kernel_row, 1'b0}) + c2d_pkg::TAP_W'(in_kernel_row) +
               c2d_pkg::TAP_W'(in_kernel_col);
  end

  assign tap_last  = (tl_r == c2d_pkg::KSEL_W'(c2d_pkg::KERNEL_SIZE - 1)) &&
                     (tm_r == c2d_pkg::KSEL_W'(c2d_pkg::KERNEL_SIZE - 1));
  assign ch_last   = (cc_r == cm1);
  assign mac_issue = cmd.mac_step && tap_ok;
  assign end_col   = (EW'(pc_r) == wm1);
  assign end_row   = (EW'(pr_r) == hm1);
  assign pipe_busy = b1_r || d1_r || v2_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign line_we = cmd.accept && (op == c2d_pkg::OP_ACT);
  assign bias_we = cmd.accept && (op == c2d_pkg::OP_BIAS);
  assign wgt_we  = cmd.accept && (op == c2d_pkg::OP_WEIGHT) &&
                   (in_kernel_row < 2'(c2d_pkg::KERNEL_SIZE)) &&
                   (in_kernel_col < 2'(c2d_pkg::KERNEL_SIZE));

  always_comb begin
    st           = '0;
    st.px_last   = (pch_r == cm1);
    st.row_match = row_ok_e && (lastr == EW'(pr_r));
    st.col_match = col_ok_e && (lastc == EW'(pc_r));
    st.no_window = (ri_r == si_r) || (cj_r == sj_r);
    st.mac_end   = tap_last && (!tap_ok || ch_last);
    st.pipe_busy = pipe_busy;
    st.out_free  = out_free;
    st.filt_last = (fi_r == fm1);
    st.win_last  = (wj_r + IW'(1) == sj_r) && (wi_r + IW'(1) == si_r);
  end

  c2d_ram #(.WIDTH(c2d_pkg::DATA_W), .DEPTH(c2d_pkg::LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr ({pslot_r, pc_r, pch_r}),
    .wdata (in_data),
    .raddr ({slot_sel, col_sel, cc_r}),
    .rdata (line_q)
  );

  c2d_ram #(.WIDTH(c2d_pkg::DATA_W), .DEPTH(c2d_pkg::WGT_DEPTH)) u_wgt (
    .clk   (clk),
    .we    (wgt_we),
    .waddr ({wr_tap, in_in_channel, in_filter_index}),
    .wdata (in_data),
    .raddr ({rd_tap, cc_r, fi_r}),
    .rdata (wgt_q)
  );

  c2d_ram #(.WIDTH(c2d_pkg::BIAS_W), .DEPTH(c2d_pkg::MAX_FILTERS)) u_bias (
    .clk   (clk),
    .we    (bias_we),
    .waddr (in_filter_index),
    .wdata (in_bias_value),
    .raddr (fi_r),
    .rdata (bias_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= DW'(c2d_pkg::RST_HEIGHT);
      w_r         <= DW'(c2d_pkg::RST_WIDTH);
      c_r         <= c2d_pkg::CNT_W'(c2d_pkg::RST_CHANNELS);
      f_r         <= c2d_pkg::CNT_W'(c2d_pkg::RST_FILTERS);
      s_r         <= c2d_pkg::STEP_W'(c2d_pkg::RST_STEP);
      p_r         <= 1'(c2d_pkg::RST_PAD);
      pr_r        <= '0;
      pc_r        <= '0;
      pch_r       <= '0;
      pslot_r     <= '0;
      ri_r        <= '0;
      cj_r        <= '0;
      re_r        <= EW'(2 - c2d_pkg::RST_PAD);
      ce_r        <= EW'(2 - c2d_pkg::RST_PAD);
      b1_r        <= 1'b0;
      d1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_r <= cmd.bias_load;
      d1_r <= mac_issue;
      v2_r <= d1_r;

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.cfg_we) begin
        case (cfg_index)
          c2d_pkg::REG_HEIGHT:   h_r <= cfg_data;
          c2d_pkg::REG_WIDTH:    w_r <= cfg_data;
          c2d_pkg::REG_CHANNELS: c_r <= cfg_data[c2d_pkg::CNT_W-1:0];
          c2d_pkg::REG_FILTERS:  f_r <= cfg_data[c2d_pkg::CNT_W-1:0];
          c2d_pkg::REG_STEP:     s_r <= cfg_data[c2d_pkg::STEP_W-1:0];
          c2d_pkg::REG_PAD:      p_r <= cfg_data[0];
          default:               p_r <= p_r;
        endcase
        if (cfg_hit) begin
          pr_r    <= '0;
          pc_r    <= '0;
          pch_r   <= '0;
          pslot_r <= '0;
          ri_r    <= '0;
          cj_r    <= '0;
          re_r    <= EW'(2) - EW'(new_p);
          ce_r    <= EW'(2) - EW'(new_p);
        end
      end

      if (line_we && !st.px_last) begin
        pch_r <= pch_r + c2d_pkg::CH_W'(1);
      end

      if (cmd.commit) begin
        pch_r <= '0;
        if (end_col) begin
          pc_r <= '0;
          cj_r <= '0;
          ce_r <= e0;
          if (end_row) begin
            pr_r    <= '0;
            pslot_r <= '0;
            ri_r    <= '0;
            re_r    <= e0;
          end else begin
            pr_r    <= pr_r + c2d_pkg::ROW_W'(1);
            pslot_r <= (pslot_r == c2d_pkg::SLOT_W'(c2d_pkg::KERNEL_SIZE - 1)) ? '0 :
                       pslot_r + c2d_pkg::SLOT_W'(1);
            ri_r    <= si_r;
            re_r    <= sie_r;
          end
        end else begin
          pc_r <= pc_r + c2d_pkg::COL_W'(1);
          cj_r <= sj_r;
          ce_r <= sje_r;
        end
      end
    end
  end

  // cursors, counters and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      si_r  <= ri_r;
      sie_r <= re_r;
      sj_r  <= cj_r;
      sje_r <= ce_r;
    end
    if (cmd.row_adv) begin
      si_r  <= si_r + IW'(1);
      sie_r <= sie_r + s_ext;
    end
    if (cmd.col_adv) begin
      sj_r  <= sj_r + IW'(1);
      sje_r <= sje_r + s_ext;
    end

    if (cmd.win_init) begin
      wi_r  <= ri_r;
      wie_r <= re_r;
      wj_r  <= cj_r;
      wje_r <= ce_r;
      fi_r  <= '0;
    end
    if (cmd.filt_next) begin
      fi_r <= fi_r + c2d_pkg::FLT_W'(1);
    end
    if (cmd.win_next) begin
      fi_r <= '0;
      if (wj_r + IW'(1) == sj_r) begin
        wj_r  <= cj_r;
        wje_r <= ce_r;
        wi_r  <= wi_r + IW'(1);
        wie_r <= wie_r + s_ext;
      end else begin
        wj_r  <= wj_r + IW'(1);
        wje_r <= wje_r + s_ext;
      end
    end

    if (cmd.bias_load) begin
      tl_r <= '0;
      tm_r <= '0;
      cc_r <= '0;
    end
    if (cmd.mac_step) begin
      if (!tap_ok || ch_last) begin
        cc_r <= '0;
        if (tm_r == c2d_pkg::KSEL_W'(c2d_pkg::KERNEL_SIZE - 1)) begin
          tm_r <= '0;
          tl_r <= tl_r + c2d_pkg::KSEL_W'(1);
        end else begin
          tm_r <= tm_r + c2d_pkg::KSEL_W'(1);
        end
      end else begin
        cc_r <= cc_r + c2d_pkg::CH_W'(1);
      end
    end

    prod_r <= $signed(line_q) * $signed(wgt_q);
    if (b1_r) begin
      acc_r <= {{(c2d_pkg::SUM_W - c2d_pkg::BIAS_W){bias_q[c2d_pkg::BIAS_W-1]}}, bias_q};
    end else if (v2_r) begin
      acc_r <= acc_r + {{(c2d_pkg::SUM_W - c2d_pkg::PROD_W){prod_r[c2d_pkg::PROD_W-1]}}, prod_r};
    end

    if (cmd.emit) begin
      out_row_r    <= wi_r[7:0];
      out_col_r    <= wj_r[7:0];
      out_filter_r <= fi_r;
      out_sum_r    <= acc_r;
      out_last_r   <= st.filt_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_filter      = out_filter_r;
  assign out_sum         = out_sum_r;
  assign out_last_of_run = out_last_r;

  `C2D_ASSERT_CLK(a_emit_drained, cmd.emit |-> !pipe_busy, "result taken before MAC pipe drained")
  `C2D_ASSERT_CLK(a_emit_free, cmd.emit |-> out_free, "result register overwritten")
  `C2D_ASSERT_CLK(a_issue_col, mac_issue |-> (DW'(col_sel) < w_eff), "MAC read outside image")
  `C2D_ASSERT_NEXT(a_commit_ch, cmd.commit, pch_r == '0, "channel count not cleared on pixel end")

endmodule

### rtl/core/conv2d_3x3_nhwc_stride_pad_core.sv
// Weight, bias, drain and non-final channel requests are taken in the idle state.
// Final channel of a pixel: row scan and column scan over the matching window rows and columns,
// window init, then per output window and per filter a bias load, the MAC loop (one shared MAC,
// one tap channel per cycle, pad taps skipped), pipe drain and result hand-off, then a commit.
// Reset (rst_n low, synchronous) restores default config, position zero and empty pipe;
// weight, bias and line stores are not cleared and must be written before use.
module conv2d_3x3_nhwc_stride_pad_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic signed [c2d_pkg::DATA_W-1:0] in_data,
  input  logic signed [c2d_pkg::BIAS_W-1:0] in_bias_value,
  input  logic [1:0]                        in_kernel_row,
  input  logic [1:0]                        in_kernel_col,
  input  logic [c2d_pkg::CH_W-1:0]          in_in_channel,
  input  logic [c2d_pkg::FLT_W-1:0]         in_filter_index,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c2d_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [c2d_pkg::CFG_DW-1:0]        cfg_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_row,
  output logic [7:0]                        out_col,
  output logic [c2d_pkg::FLT_W-1:0]         out_filter,
  output logic signed [c2d_pkg::SUM_W-1:0]  out_sum,
  output logic                              out_last_of_run
);

  // controller issues commands, datapath reports status
  c2d_pkg::cmd_t  cmd;
  c2d_pkg::stat_t st;

  c2d_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .cfg_valid    (cfg_valid),
    .st           (st),
    .in_stall     (in_stall),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd)
  );

  // datapath holds stores, line position, window cursors, MAC and the result register,
  // so a finished result can wait on out_stall while the controller computes the next one
  c2d_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_operation    (in_operation),
    .in_data         (in_data),
    .in_bias_value   (in_bias_value),
    .in_kernel_row   (in_kernel_row),
    .in_kernel_col   (in_kernel_col),
    .in_in_channel   (in_in_channel),
    .in_filter_index (in_filter_index),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_filter      (out_filter),
    .out_sum         (out_sum),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the 3x3 NHWC convolution core with stride, padding and bias.
module tb_top;
  import c2d_pkg::*;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  LONG_HOLD    = 400;
  localparam int  CFG_SETTLE   = 60;
  localparam int  DRAIN_WAIT   = 200;
  localparam int  RAND_ITEMS   = 262;
  localparam int  QUIET_AFTER  = 220;
  localparam int  DIR_ROWS     = 33;
  // index beyond the register list; the block must ignore it
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
  localparam logic ROW_REQ = 1'b0;
  localparam logic ROW_CFG = 1'b1;

  // one expected result
  typedef struct packed {
    logic [7:0]       row;
    logic [7:0]       col;
    logic [FLT_W-1:0] filt;
    logic [SUM_W-1:0] sum;
    logic             last;
  } conv_sum_t;

  // directed row: a request, or a config write (index in ch[2:0], value in data[8:0])
  typedef struct packed {
    logic             kind;
    logic [1:0]       op;
    logic [15:0]      data;
    logic [31:0]      bias;
    logic [1:0]       kr;
    logic [1:0]       kc;
    logic [5:0]       ch;
    logic [5:0]       f;
    logic             chk;
    logic [SUM_W-1:0] sum;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_operation;
  logic signed [DATA_W-1:0] in_data;
  logic signed [BIAS_W-1:0] in_bias_value;
  logic [1:0] in_kernel_row, in_kernel_col;
  logic [CH_W-1:0] in_in_channel;
  logic [FLT_W-1:0] in_filter_index;
  logic cfg_valid, cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic out_valid, out_stall;
  logic [7:0] out_row, out_col;
  logic [FLT_W-1:0] out_filter;
  logic signed [SUM_W-1:0] out_sum;
  logic out_last_of_run;

  conv2d_3x3_nhwc_stride_pad_core DUT (.*);

  // predictor state: stores, position and raw register values
  logic signed [DATA_W-1:0] wgt_mem [0:WGT_DEPTH-1];
  logic signed [BIAS_W-1:0] bias_mem [0:MAX_FILTERS-1];
  logic signed [DATA_W-1:0] line_mem [0:LINE_DEPTH-1];
  int cur_row, cur_col, cur_ch;
  int reg_h, reg_w, reg_c, reg_f, reg_s, reg_p;

  conv_sum_t pending_sums [$];   // results still owed by the block
  conv_sum_t fresh_sums [$];     // results caused by the latest request
  int  errors = 0;
  int  cycles = 0;
  int  rand_items = 0;
  bit  counting = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  bit  hold_done;
  int  hold_cnt, burst_cnt;
  dir_row_t dir_tab [0:DIR_ROWS-1];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("conv2d_3x3_nhwc_stride_pad_core verification failed");
      $finish;
    end
  end

  function automatic int clampv(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int odim(int n, int p, int s);
    return (n + 2 * p < KERNEL_SIZE) ? 0 : (n + 2 * p - KERNEL_SIZE) / s + 1;
  endfunction

  // last real pixel a window edge needs, clamped into the image
  function automatic int last_real(int start, int lim);
    return clampv(start + KERNEL_SIZE - 1, 0, lim - 1);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // all windows whose last real pixel is (r, c), in raster order
  task automatic queue_windows(input int r, input int c);
    int hh, ww, cc_n, ff, s, p, rr, cc;
    longint acc;
    hh = clampv(reg_h, 1, MAX_HEIGHT);
    ww = clampv(reg_w, 1, MAX_WIDTH);
    cc_n = clampv(reg_c, 1, MAX_CHANNELS);
    ff = clampv(reg_f, 1, MAX_FILTERS);
    s = clampv(reg_s, 1, STEP_MAX);
    p = reg_p & 1;
    for (int i = 0; i < odim(hh, p, s); i++) begin
      if (last_real(i * s - p, hh) != r) continue;
      for (int j = 0; j < odim(ww, p, s); j++) begin
        if (last_real(j * s - p, ww) != c) continue;
        for (int f = 0; f < ff; f++) begin
          acc = longint'(bias_mem[f]);
          for (int l = 0; l < KERNEL_SIZE; l++) begin
            rr = i * s + l - p;
            if (rr < 0 || rr >= hh) continue;
            for (int m = 0; m < KERNEL_SIZE; m++) begin
              cc = j * s + m - p;
              if (cc < 0 || cc >= ww) continue;
              for (int ch = 0; ch < cc_n; ch++)
                acc += longint'(line_mem[((rr % KERNEL_SIZE) * MAX_WIDTH + cc) * MAX_CHANNELS + ch])
                     * longint'(wgt_mem[((l * KERNEL_SIZE + m) * MAX_CHANNELS + ch)
                                        * MAX_FILTERS + f]);
            end
          end
          fresh_sums.push_back('{i[7:0], j[7:0], f[FLT_W-1:0], acc[SUM_W-1:0], f == ff - 1});
        end
      end
    end
  endtask

  task automatic conv_predict(input logic [1:0] op, input logic [15:0] d, input logic [31:0] b,
                              input logic [1:0] kr, input logic [1:0] kc,
                              input logic [5:0] ch, input logic [5:0] f);
    int hh, ww, cc_n;
    hh = clampv(reg_h, 1, MAX_HEIGHT);
    ww = clampv(reg_w, 1, MAX_WIDTH);
    cc_n = clampv(reg_c, 1, MAX_CHANNELS);
    case (op_t'(op))
      OP_WEIGHT: begin
        if (kr < KERNEL_SIZE && kc < KERNEL_SIZE)
          wgt_mem[((kr * KERNEL_SIZE + kc) * MAX_CHANNELS + ch) * MAX_FILTERS + f] = d;
      end
      OP_BIAS: bias_mem[f] = b;
      OP_ACT: begin
        if (cur_row >= hh || cur_col >= ww || cur_ch >= cc_n) begin
          cur_row = 0; cur_col = 0; cur_ch = 0;
        end
        line_mem[((cur_row % KERNEL_SIZE) * MAX_WIDTH + cur_col) * MAX_CHANNELS + cur_ch] = d;
        if (cur_ch + 1 < cc_n) begin
          cur_ch++;
        end else begin
          queue_windows(cur_row, cur_col);
          cur_ch = 0;
          if (++cur_col >= ww) begin
            cur_col = 0;
            if (++cur_row >= hh) cur_row = 0;
          end
        end
      end
      default: ;   // drain: nothing stored
    endcase
  endtask

  // offer one request, wait for it, then predict; typed rows replace the predicted sum
  task automatic send_req(input logic [1:0] op, input logic [15:0] d, input logic [31:0] b,
                          input logic [1:0] kr, input logic [1:0] kc,
                          input logic [5:0] ch, input logic [5:0] f,
                          input logic typed, input logic [SUM_W-1:0] tsum);
    in_valid <= 1'b1;
    in_operation <= op;
    in_data <= d;
    in_bias_value <= b;
    in_kernel_row <= kr;
    in_kernel_col <= kc;
    in_in_channel <= ch;
    in_filter_index <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    conv_predict(op, d, b, kr, kc, ch, f);
    if (typed) begin
      fresh_sums.delete();
      pending_sums.push_back('{8'd0, 8'd0, '0, tsum, 1'b1});
    end else begin
      while (fresh_sums.size() > 0) pending_sums.push_back(fresh_sums.pop_front());
    end
    if (counting) rand_items++;
    if (rand_items >= QUIET_AFTER) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // registers change only with the block idle
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] v);
    in_valid <= 1'b0;
    while (pending_sums.size() > 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (reg_idx_t'(idx))
      REG_HEIGHT:   reg_h = v;
      REG_WIDTH:    reg_w = v;
      REG_CHANNELS: reg_c = v & 7'h7f;
      REG_FILTERS:  reg_f = v & 7'h7f;
      REG_STEP:     reg_s = v & 3'h7;
      REG_PAD:      reg_p = v & 1'b1;
      default: return;   // unknown index: no effect, position kept
    endcase
    cur_row = 0; cur_col = 0; cur_ch = 0;
  endtask

  // receiver: random stall bursts, one long hold, none near the end
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      burst_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (burst_cnt > 0) begin
      burst_cnt <= burst_cnt - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      burst_cnt <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    conv_sum_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result row %0d col %0d filter %0d sum %0d",
               out_row, out_col, out_filter, out_sum);
        errors++;
      end else begin
        e = pending_sums.pop_front();
        if (out_row !== e.row) begin
          $error("out_row expected %0d actual %0d", e.row, out_row); errors++;
        end
        if (out_col !== e.col) begin
          $error("out_col expected %0d actual %0d", e.col, out_col); errors++;
        end
        if (out_filter !== e.filt) begin
          $error("out_filter expected %0d actual %0d", e.filt, out_filter); errors++;
        end
        if (out_sum !== e.sum) begin
          $error("out_sum expected %0d actual %0d", $signed(e.sum), out_sum); errors++;
        end
        if (out_last_of_run !== e.last) begin
          $error("out_last_of_run expected %0d actual %0d", e.last, out_last_of_run); errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int hh, ww, cc_n, n_img, total, cut;
    bit broken;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_data = '0;
    in_bias_value = '0;
    in_kernel_row = '0;
    in_kernel_col = '0;
    in_in_channel = '0;
    in_filter_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_h = RST_HEIGHT; reg_w = RST_WIDTH; reg_c = RST_CHANNELS;
    reg_f = RST_FILTERS; reg_s = RST_STEP; reg_p = RST_PAD;
    cur_row = 0; cur_col = 0; cur_ch = 0;

    // single center tap is the only real one in a 1x1 padded image
    dir_tab = '{
      '{ROW_REQ, OP_WEIGHT, 16'h7fff, 32'd0, 2'd1, 2'd1, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_WEIGHT, 16'hffff, 32'd0, 2'd3, 2'd0, 6'd63, 6'd63, 1'b0, 48'd0},
      '{ROW_REQ, OP_WEIGHT, 16'hffff, 32'd0, 2'd0, 2'd3, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_BIAS, 16'd0, 32'h7fffffff, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_BIAS, 16'd0, 32'h80000000, 2'd0, 2'd0, 6'd0, 6'd63, 1'b0, 48'd0},
      '{ROW_REQ, OP_DRAIN, 16'd0, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_HEIGHT}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_WIDTH}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_CHANNELS}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_FILTERS}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_STEP}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_PAD}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd511, 32'd0, 2'd0, 2'd0, {3'd0, REG_UNUSED}, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'h8000, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b1, 48'sd1073774591},
      '{ROW_REQ, OP_ACT, 16'h7fff, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b1, 48'sd3221159936},
      '{ROW_REQ, OP_BIAS, 16'd0, 32'h80000000, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'h8000, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b1, -48'sd3221192704},
      '{ROW_REQ, OP_ACT, 16'h0000, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b1, -48'sd2147483648},
      '{ROW_CFG, 2'd0, 16'd0, 32'd0, 2'd0, 2'd0, {3'd0, REG_PAD}, 6'd0, 1'b0, 48'd0},
      // unpadded 1x1 image: no window at all
      '{ROW_REQ, OP_ACT, 16'd5, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd1, 32'd0, 2'd0, 2'd0, {3'd0, REG_PAD}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd3, 32'd0, 2'd0, 2'd0, {3'd0, REG_HEIGHT}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd3, 32'd0, 2'd0, 2'd0, {3'd0, REG_WIDTH}, 6'd0, 1'b0, 48'd0},
      '{ROW_CFG, 2'd0, 16'd2, 32'd0, 2'd0, 2'd0, {3'd0, REG_FILTERS}, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'h7fff, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'h8000, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'd1, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'hffff, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'd100, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'hff38, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'h7fff, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'h8000, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0},
      '{ROW_REQ, OP_ACT, 16'd7, 32'd0, 2'd0, 2'd0, 6'd0, 6'd0, 1'b0, 48'd0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // preload every weight and bias the windows below can read (up to 3 channels, 3 filters)
    for (int kr = 0; kr < KERNEL_SIZE; kr++)
      for (int kc = 0; kc < KERNEL_SIZE; kc++)
        for (int ch = 0; ch < 3; ch++)
          for (int f = 0; f < 3; f++)
            send_req(OP_WEIGHT, pick16(), 32'd0, 2'(kr), 2'(kc), 6'(ch), 6'(f), 1'b0, '0);
    for (int f = 0; f < 3; f++)
      send_req(OP_BIAS, 16'd0, $urandom, 2'd0, 2'd0, 6'd0, 6'(f), 1'b0, '0);

    // directed part
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].kind == ROW_CFG)
        cfg_write(dir_tab[k].ch[CFG_IW-1:0], dir_tab[k].data[CFG_DW-1:0]);
      else
        send_req(dir_tab[k].op, dir_tab[k].data, dir_tab[k].bias, dir_tab[k].kr,
                 dir_tab[k].kc, dir_tab[k].ch, dir_tab[k].f, dir_tab[k].chk, dir_tab[k].sum);
    end

    // random phases: whole images with random content, noise, some cut short
    counting = 1'b1;
    for (int phase = 0; rand_items < RAND_ITEMS; phase++) begin
      if (phase == 1) begin
        // extremes: clamped zero sizes, full 256 columns, stride clamped to 4
        cfg_write(REG_HEIGHT, 9'd0);
        cfg_write(REG_WIDTH, 9'd511);
        cfg_write(REG_CHANNELS, 9'd0);
        cfg_write(REG_FILTERS, 9'd0);
        cfg_write(REG_STEP, 9'd7);
        cfg_write(REG_PAD, 9'd1);
      end else begin
        cfg_write(REG_HEIGHT, ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 5)));
        cfg_write(REG_WIDTH, ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 6)));
        cfg_write(REG_CHANNELS, 9'($urandom_range(0, 3)));
        cfg_write(REG_FILTERS, 9'($urandom_range(0, 3)));
        cfg_write(REG_STEP, 9'($urandom_range(0, 7)));
        cfg_write(REG_PAD, 9'($urandom_range(0, 1)));
      end
      // the wide image always has windows, so the long hold backs up the input
      if (phase == 1) hold_req = 1'b1;
      hh = clampv(reg_h, 1, MAX_HEIGHT);
      ww = clampv(reg_w, 1, MAX_WIDTH);
      cc_n = clampv(reg_c, 1, MAX_CHANNELS);
      total = hh * ww * cc_n;
      n_img = (phase == 1) ? 1 : $urandom_range(1, 2);
      broken = 1'b0;
      for (int img = 0; img < n_img && !broken; img++) begin
        broken = (phase != 1) && ($urandom_range(0, 7) == 0);
        cut = $urandom_range(0, total - 1);
        for (int k = 0; k < total; k++) begin
          if (broken && k == cut) break;
          if ($urandom_range(0, 5) == 0)
            send_req($urandom_range(0, 2) == 2 ? OP_DRAIN : 2'($urandom_range(0, 1)), pick16(),
                     $urandom, 2'($urandom), 2'($urandom), 6'($urandom), 6'($urandom),
                     1'b0, '0);
          send_req(OP_ACT, pick16(), $urandom, 2'($urandom), 2'($urandom), 6'($urandom),
                   6'($urandom), 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_sums.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("conv2d_3x3_nhwc_stride_pad_core verification clean");
    else
      $display("conv2d_3x3_nhwc_stride_pad_core verification failed");
    $finish;
  end

endmodule
